// File: rtl/jsu_pkg.sv
// jsu_pkg: shared types, character codes and helpers for the json string unescape unit
// no dependencies; imported by json_string_unescape_utf8_unit, unescape_checker and testbench
`timescale 1ns / 1ps

package jsu_pkg;

    typedef enum logic [3:0] {
        MODE_DONE   = 4'b0001,
        MODE_NORMAL = 4'b0010,
        MODE_ESC    = 4'b0100,
        MODE_HEX    = 4'b1000
    } mode_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam logic [15:0] UTF8_LIM1  = 16'h0080;
    localparam logic [15:0] UTF8_LIM2  = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;

    localparam int GRP_DEPTH = 5;

    typedef logic [7:0] byte_t;

    // bit 4 set when the character is a hex digit, low bits give its value
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
            r = {1'b1, 4'(c - 8'h30)};
        else if (c inside {[8'h61:8'h66]})
            r = {1'b1, 4'(c - 8'h57)};
        else if (c inside {[8'h41:8'h46]})
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

endpackage

// File: rtl/json_string_unescape_utf8_unit.sv
// json_string_unescape_utf8_unit: streaming decoder for the body of a json string value
// depends on jsu_pkg
`timescale 1ns / 1ps

// Input channel s_axis: one body byte per word. tdata is the raw byte, tuser[0] marks the
// first byte after the opening quote (restarts the decoder), tlast marks the final byte.
// Output channel m_axis: one decoded result per word. tdata is the decoded byte, tuser
// carries byte_valid, value_end and closed, tlast marks the last result of an input word.
// An input word yields zero to five results. They are computed in the cycle the word is
// accepted and held in a result group register; they appear on m_axis in the next cycle,
// one result per cycle unless m_axis stalls. The group register frees up in the cycle its
// last result is taken, so words that yield at most one result stream at one word per
// clock unless m_axis stalls; a word that yields more holds the input until its last
// result leaves the single output port. Words that yield nothing (escape start, bytes
// after the closing quote) load no group. Reset leaves the decoder in the done state,
// ignoring bytes until a first byte arrives, with an empty result group. When m_axis
// stalls, the group holds and s_axis keeps tready low until its last result is taken.
module json_string_unescape_utf8_unit
    import jsu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic [0:0]  s_axis_tuser,   // first_byte
    input  logic        s_axis_tlast,   // end_of_body
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic [2:0]  m_axis_tuser,   // byte_valid, value_end, closed
    output logic        m_axis_tlast    // run_last
);

    mode_t       mode_reg, mode_next;
    logic [1:0]  digits_reg, digits_next;
    logic [15:0] cp_reg, cp_next;
    byte_t       raw_reg [3];
    byte_t       raw_next [3];

    logic        grp_valid_reg;
    logic [2:0]  idx_reg;
    logic [2:0]  cnt_reg, cnt_next;
    logic [2:0]  nbytes_reg, nbytes_next;
    logic        ve_reg, ve_next;
    logic        closed_reg, closed_next;
    byte_t       grp_reg [GRP_DEPTH];
    byte_t       grp_next [GRP_DEPTH];

    mode_t       mode_in;
    logic [1:0]  dig_in;
    logic [15:0] cp_in;
    logic [7:0]  b;
    logic        eob;
    logic        active;
    logic        plain_en;
    logic        closed_now;
    logic        raw_wr;
    logic        flush_en;
    logic [1:0]  flush_cnt;
    logic [2:0]  flush_len;
    logic [1:0]  main_n;
    byte_t       main_b [3];
    logic [4:0]  nib;
    logic        has_res;
    logic        in_acc;
    logic        out_acc;
    logic        out_last;
    logic        bv;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_acc  = m_axis_tvalid && m_axis_tready;
    assign out_last = (idx_reg == cnt_reg - 3'd1);
    assign s_axis_tready = !grp_valid_reg || (m_axis_tready && out_last);

    always_comb
    begin
        b       = s_axis_tdata;
        eob     = s_axis_tlast;
        mode_in = s_axis_tuser[0] ? MODE_NORMAL : mode_reg;
        dig_in  = s_axis_tuser[0] ? 2'd0 : digits_reg;
        cp_in   = s_axis_tuser[0] ? 16'd0 : cp_reg;

        mode_next   = mode_in;
        digits_next = dig_in;
        cp_next     = cp_in;
        raw_wr      = 1'b0;
        plain_en    = 1'b0;
        closed_now  = 1'b0;
        flush_en    = 1'b0;
        flush_cnt   = 2'd0;
        main_n      = 2'd0;
        main_b[0]   = 8'd0;
        main_b[1]   = 8'd0;
        main_b[2]   = 8'd0;
        nib         = nibble_of(b);
        active      = (mode_in != MODE_DONE);

        case (mode_in)
            MODE_NORMAL:
            begin
                plain_en = 1'b1;
            end
            MODE_ESC:
            begin
                mode_next = MODE_NORMAL;
                if (b == CH_N)
                begin
                    main_b[0] = CH_LF;
                    main_n    = 2'd1;
                end
                else if (b == CH_T)
                begin
                    main_b[0] = CH_TAB;
                    main_n    = 2'd1;
                end
                else if (b == CH_R)
                begin
                    main_n = 2'd0;
                end
                else if (b == CH_U)
                begin
                    mode_next   = MODE_HEX;
                    digits_next = 2'd0;
                    cp_next     = 16'd0;
                end
                else
                begin
                    main_b[0] = b;
                    main_n    = 2'd1;
                end
            end
            MODE_HEX:
            begin
                if (nib[4])
                begin
                    cp_next = {cp_in[11:0], nib[3:0]};
                    if (dig_in == 2'd3)
                    begin
                        digits_next = 2'd0;
                        mode_next   = MODE_NORMAL;
                        if (cp_next < UTF8_LIM1)
                        begin
                            main_b[0] = cp_next[7:0];
                            main_n    = 2'd1;
                        end
                        else if (cp_next < UTF8_LIM2)
                        begin
                            main_b[0] = UTF8_LEAD2 | {3'd0, cp_next[10:6]};
                            main_b[1] = UTF8_CONT | {2'd0, cp_next[5:0]};
                            main_n    = 2'd2;
                        end
                        else
                        begin
                            main_b[0] = UTF8_LEAD3 | {4'd0, cp_next[15:12]};
                            main_b[1] = UTF8_CONT | {2'd0, cp_next[11:6]};
                            main_b[2] = UTF8_CONT | {2'd0, cp_next[5:0]};
                            main_n    = 2'd3;
                        end
                    end
                    else
                    begin
                        raw_wr      = 1'b1;
                        digits_next = dig_in + 2'd1;
                    end
                end
                else
                begin
                    flush_en    = 1'b1;
                    flush_cnt   = dig_in;
                    digits_next = 2'd0;
                    mode_next   = MODE_NORMAL;
                    plain_en    = 1'b1;
                end
            end
            default:
            begin
                active = 1'b0;
            end
        endcase

        if (plain_en)
        begin
            if (b == CH_BSLASH)
                mode_next = MODE_ESC;
            else if (b == CH_QUOTE)
            begin
                mode_next  = MODE_DONE;
                closed_now = 1'b1;
            end
            else
            begin
                main_b[0] = b;
                main_n    = 2'd1;
            end
        end

        // body ran out: pending hex digits go out raw
        if (active && eob && !closed_now)
        begin
            if (mode_next == MODE_HEX)
            begin
                flush_en    = 1'b1;
                flush_cnt   = digits_next;
                digits_next = 2'd0;
            end
            mode_next = MODE_DONE;
        end

        raw_next[0] = raw_reg[0];
        raw_next[1] = raw_reg[1];
        raw_next[2] = raw_reg[2];
        if (raw_wr)
            raw_next[dig_in] = b;

        flush_len = flush_en ? ({1'b0, flush_cnt} + 3'd1) : 3'd0;
        for (int i = 0; i < GRP_DEPTH; i++)
            grp_next[i] = 8'd0;
        if (flush_en)
        begin
            grp_next[0]         = CH_U;
            grp_next[1]         = raw_next[0];
            grp_next[2]         = raw_next[1];
            grp_next[3]         = raw_next[2];
            grp_next[flush_len] = main_b[0];
        end
        else
        begin
            grp_next[0] = main_b[0];
            grp_next[1] = main_b[1];
            grp_next[2] = main_b[2];
        end

        nbytes_next = flush_len + {1'b0, main_n};
        ve_next     = active && (closed_now || eob);
        closed_next = active && closed_now;
        cnt_next    = (nbytes_next == 3'd0) ? 3'd1 : nbytes_next;
        has_res     = (nbytes_next != 3'd0) || ve_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_DONE;
            digits_reg    <= 2'd0;
            cp_reg        <= 16'd0;
            grp_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            if (in_acc)
            begin
                mode_reg   <= mode_next;
                digits_reg <= digits_next;
                cp_reg     <= cp_next;
            end
            if (in_acc && has_res)
            begin
                grp_valid_reg <= 1'b1;
                idx_reg       <= 3'd0;
            end
            else if (out_acc && out_last)
            begin
                grp_valid_reg <= 1'b0;
                idx_reg       <= 3'd0;
            end
            else if (out_acc)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            raw_reg <= raw_next;
        end
        if (in_acc && has_res)
        begin
            grp_reg    <= grp_next;
            cnt_reg    <= cnt_next;
            nbytes_reg <= nbytes_next;
            ve_reg     <= ve_next;
            closed_reg <= closed_next;
        end
    end

    assign bv            = (idx_reg < nbytes_reg);
    assign m_axis_tvalid = grp_valid_reg;
    assign m_axis_tdata  = bv ? grp_reg[idx_reg] : 8'd0;
    assign m_axis_tuser  = {closed_reg && out_last, ve_reg && out_last, bv};
    assign m_axis_tlast  = out_last;

    // group index stays inside the loaded group
    a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid_reg |-> (idx_reg < cnt_reg) && (cnt_reg != 3'd0) && (cnt_reg <= 3'd5))
        else $error("result index outside group");

    // end of value is only flagged on the last result of a word
    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
        else $error("value end not on last result");

    a_closed_with_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |-> m_axis_tuser[1])
        else $error("closed without value end");

    // pending hex digits only exist inside a unicode escape
    a_digits_in_hex: assert property (@(posedge clk) disable iff (!rst_n)
        (digits_reg != 2'd0) |-> (mode_reg == MODE_HEX))
        else $error("hex digits pending outside escape");

    // a stalled group holds until taken
    a_group_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(idx_reg)))
        else $error("stalled result group changed");

endmodule

// File: test/unescape_checker.sv
// unescape_checker: watches both stream channels of the json string unescape unit,
// predicts the decoded words for every accepted input word and compares them in order
// depends on jsu_pkg; instantiated by testbench
`timescale 1ns / 1ps

module unescape_checker
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // in_byte
    input  logic [0:0] s_axis_tuser,    // first_byte
    input  logic       s_axis_tlast,    // end_of_body
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,    // out_byte
    input  logic [2:0] m_axis_tuser,    // byte_valid, value_end, closed
    input  logic       m_axis_tlast,    // run_last
    output int         fail_count,
    output int         pending,
    output int         words_in,
    output int         results_out,
    output int         values_ended,
    output int         values_closed
);

    typedef struct packed {
        byte_t data;
        logic  byte_valid;
        logic  value_end;
        logic  closed;
        logic  run_last;
    } dec_result_t;

    mode_t       dec_mode;
    logic [1:0]  digits;
    logic [15:0] cp;
    byte_t       hex_raw [3];
    logic        closed_now;
    dec_result_t step_q [$];
    dec_result_t expected_q [$];
    dec_result_t want;

    task automatic report_error(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    task automatic compare_field(input string what, input int got, input int exp_val);
        if (got != exp_val)
            report_error($sformatf("result %0d %s got 0x%0h, expected 0x%0h",
                                   results_out, what, got, exp_val));
    endtask

    function automatic int hex_value(input byte_t c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic void put_byte(input byte_t b);
        dec_result_t r;
        r = '0;
        r.data = b;
        r.byte_valid = 1'b1;
        step_q.push_back(r);
    endfunction

    // a cut-short \u escape comes out as the letter and the digits seen so far
    function automatic void dump_hex();
        put_byte(CH_U);
        for (int k = 0; k < int'(digits); k++)
            put_byte(hex_raw[k]);
        digits = 2'd0;
    endfunction

    function automatic void take_plain(input byte_t b);
        if (b == CH_BSLASH)
            dec_mode = MODE_ESC;
        else if (b == CH_QUOTE)
        begin
            dec_mode = MODE_DONE;
            closed_now = 1'b1;
        end
        else
            put_byte(b);
    endfunction

    function automatic void put_utf8(input logic [15:0] c);
        if (c < UTF8_LIM1)
            put_byte(c[7:0]);
        else if (c < UTF8_LIM2)
        begin
            put_byte(UTF8_LEAD2 | c[13:6]);
            put_byte(UTF8_CONT | {2'b00, c[5:0]});
        end
        else
        begin
            put_byte(UTF8_LEAD3 | {4'h0, c[15:12]});
            put_byte(UTF8_CONT | {2'b00, c[11:6]});
            put_byte(UTF8_CONT | {2'b00, c[5:0]});
        end
    endfunction

    function automatic void decode_word(input byte_t b, input logic fb, input logic eob);
        int nib;
        int last;
        step_q.delete();
        closed_now = 1'b0;
        if (fb)
        begin
            dec_mode = MODE_NORMAL;
            digits = 2'd0;
            cp = 16'd0;
        end
        if (dec_mode == MODE_DONE)
            return;

        case (dec_mode)
            MODE_NORMAL:
                take_plain(b);
            MODE_ESC:
            begin
                dec_mode = MODE_NORMAL;
                if (b == CH_N)
                    put_byte(CH_LF);
                else if (b == CH_T)
                    put_byte(CH_TAB);
                else if (b == CH_U)
                begin
                    dec_mode = MODE_HEX;
                    digits = 2'd0;
                    cp = 16'd0;
                end
                else if (b != CH_R)
                    put_byte(b);
            end
            default:
            begin
                nib = hex_value(b);
                if (nib >= 0)
                begin
                    cp = {cp[11:0], nib[3:0]};
                    if (digits == 2'd3)
                    begin
                        put_utf8(cp);
                        digits = 2'd0;
                        dec_mode = MODE_NORMAL;
                    end
                    else
                    begin
                        hex_raw[digits] = b;
                        digits = digits + 2'd1;
                    end
                end
                else
                begin
                    dump_hex();
                    dec_mode = MODE_NORMAL;
                    take_plain(b);
                end
            end
        endcase

        if (!closed_now && eob)
        begin
            if (dec_mode == MODE_HEX)
                dump_hex();
            dec_mode = MODE_DONE;
        end

        if (closed_now || eob)
        begin
            if (step_q.size() == 0)
                step_q.push_back('0);
            last = step_q.size() - 1;
            step_q[last].value_end = 1'b1;
            step_q[last].closed = closed_now;
        end
        if (step_q.size() > 0)
        begin
            last = step_q.size() - 1;
            step_q[last].run_last = 1'b1;
        end
        foreach (step_q[i])
            expected_q.push_back(step_q[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_mode = MODE_DONE;
            digits = 2'd0;
            cp = 16'd0;
            expected_q.delete();
            fail_count = 0;
            words_in = 0;
            results_out = 0;
            values_ended = 0;
            values_closed = 0;
            pending <= 0;
        end
        else
        begin
            // results first: a word accepted at this edge cannot show up before the next one
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_out++;
                if (expected_q.size() == 0)
                    report_error($sformatf("result %0d (0x%0h) arrived with none expected",
                                           results_out, m_axis_tdata));
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("out_byte", m_axis_tdata, want.data);
                    compare_field("byte_valid", m_axis_tuser[0], want.byte_valid);
                    compare_field("value_end", m_axis_tuser[1], want.value_end);
                    compare_field("closed", m_axis_tuser[2], want.closed);
                    compare_field("run_last", m_axis_tlast, want.run_last);
                    if (want.value_end)
                    begin
                        values_ended++;
                        if (want.closed)
                            values_closed++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                words_in++;
                decode_word(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
            end
            pending <= expected_q.size();
        end
    end

endmodule

// File: test/testbench.sv
// testbench: drives json_string_unescape_utf8_unit with directed and random string bodies
// under random idling on both channels; checking lives in unescape_checker
// depends on jsu_pkg, json_string_unescape_utf8_unit and unescape_checker
`timescale 1ns / 1ps

module testbench
    import jsu_pkg::*;
;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_EXTRA = 6;
    localparam int RANDOM_ITEMS = 130;
    localparam int HOLD_CYCLES = 150;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;    // in_byte
    logic [0:0] s_axis_tuser = 1'b0;     // first_byte
    logic       s_axis_tlast = 1'b0;     // end_of_body
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // out_byte
    logic [2:0] m_axis_tuser;            // byte_valid, value_end, closed
    logic       m_axis_tlast;            // run_last

    int fail_count;
    int pending;
    int words_in;
    int results_out;
    int values_ended;
    int values_closed;

    logic  tx_idle = 1'b1;
    logic  rx_idle = 1'b1;
    int    rx_hold = 0;
    int    rand_items = 0;
    int    cycle_count = 0;
    byte_t body_q [$];

    json_string_unescape_utf8_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    unescape_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_in      (words_in),
        .results_out   (results_out),
        .values_ended  (values_ended),
        .values_closed (values_closed)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random stall per word, plus a long hold when asked
    initial
    begin
        int gap;
        int hold;
        forever
        begin
            if (rx_hold > 0)
            begin
                hold = rx_hold;
                rx_hold = 0;
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            gap = rx_idle ? $urandom_range(0, 9) : 0;
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_word(input byte_t d, input logic fb, input logic lst);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= fb;
        s_axis_tlast <= lst;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic send_text(input string s, input logic fb_first, input logic eob_last);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], fb_first && i == 0, eob_last && i == s.len() - 1);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_EXTRA) @(posedge clk);
    endtask

    task automatic push_hex(input logic [3:0] v);
        if (v < 4'd10)
            body_q.push_back(byte_t'("0") + v);
        else if ($urandom_range(0, 1))
            body_q.push_back(byte_t'("a") + v - 4'd10);
        else
            body_q.push_back(byte_t'("A") + v - 4'd10);
    endtask

    // one random string body: tokens, then an ending; bytes after a closing quote are
    // junk that the block ignores and do not count as items
    task automatic play_random_value();
        int ntok;
        int k;
        int eob_at;
        int live_len;
        logic [15:0] cp;
        byte_t b;
        body_q.delete();
        eob_at = -1;
        ntok = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        for (int t = 0; t < ntok; t++)
        begin
            k = $urandom_range(0, 99);
            if (k < 40)
            begin
                do b = byte_t'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
                body_q.push_back(b);
            end
            else if (k < 60)
            begin
                body_q.push_back(CH_BSLASH);
                case ($urandom_range(0, 6))
                    0: body_q.push_back(CH_N);
                    1: body_q.push_back(CH_T);
                    2: body_q.push_back(CH_R);
                    3: body_q.push_back(CH_QUOTE);
                    4: body_q.push_back(CH_BSLASH);
                    5: body_q.push_back("/");
                    default: body_q.push_back(byte_t'($urandom_range(0, 255)));
                endcase
            end
            else if (k < 90)
            begin
                case ($urandom_range(0, 3))
                    0: cp = 16'($urandom_range(0, 16'h007F));
                    1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                    default:
                    begin
                        case ($urandom_range(0, 7))
                            0: cp = 16'h0000;
                            1: cp = 16'h007F;
                            2: cp = 16'h0080;
                            3: cp = 16'h07FF;
                            4: cp = 16'h0800;
                            5: cp = 16'hD800;
                            6: cp = 16'hDFFF;
                            default: cp = 16'hFFFF;
                        endcase
                    end
                endcase
                body_q.push_back(CH_BSLASH);
                body_q.push_back(CH_U);
                push_hex(cp[15:12]);
                push_hex(cp[11:8]);
                push_hex(cp[7:4]);
                push_hex(cp[3:0]);
            end
            else
            begin
                // broken \u: up to three digits then a non-hex byte
                body_q.push_back(CH_BSLASH);
                body_q.push_back(CH_U);
                repeat ($urandom_range(0, 3)) push_hex(4'($urandom_range(0, 15)));
                case ($urandom_range(0, 3))
                    0: body_q.push_back(CH_BSLASH);
                    1: body_q.push_back(byte_t'($urandom_range(8'h67, 8'hFF)));
                    2: body_q.push_back(byte_t'($urandom_range(8'h00, 8'h21)));
                    default: body_q.push_back(byte_t'($urandom_range(8'h47, 8'h5B)));
                endcase
            end
        end

        k = $urandom_range(0, 99);
        if (k < 45)
            body_q.push_back(CH_QUOTE);
        else if (k < 55)
        begin
            body_q.push_back(CH_QUOTE);
            eob_at = body_q.size() - 1;
        end
        else if (k < 80)
        begin
            if (body_q.size() == 0)
                body_q.push_back(byte_t'($urandom_range(0, 255)));
            eob_at = body_q.size() - 1;
        end
        else if (k < 90)
        begin
            body_q.push_back(CH_BSLASH);
            body_q.push_back(CH_U);
            repeat ($urandom_range(0, 3)) push_hex(4'($urandom_range(0, 15)));
            eob_at = body_q.size() - 1;
        end
        else if (k < 95)
        begin
            body_q.push_back(CH_BSLASH);
            eob_at = body_q.size() - 1;
        end
        else
        begin
            // left open inside an escape; the next first byte restarts the decoder
            body_q.push_back(CH_BSLASH);
            body_q.push_back(CH_U);
            push_hex(4'($urandom_range(0, 15)));
        end
        live_len = body_q.size();
        if (k < 45)
            repeat ($urandom_range(0, 2)) body_q.push_back(byte_t'($urandom_range(0, 255)));

        foreach (body_q[i])
            send_word(body_q[i], i == 0, i == eob_at);
        rand_items += live_len;
    endtask

    initial
    begin
        int  burst_end;
        bit  paused;
        paused = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: ignored while done, empty value, byte extremes, every escape,
        // utf-8 top code point, five-result flush, bad digit on a quote, cut-off bodies
        send_text("z", 1'b0, 1'b0);
        send_text("\"", 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_text("\\n\\t\\r\\\"\\\\\\/", 1'b0, 1'b0);
        send_text("\\uFfFf", 1'b0, 1'b0);
        send_text("\\u123g", 1'b0, 1'b0);
        send_text("\\u4\"", 1'b0, 1'b0);
        send_text("a\\", 1'b1, 1'b1);
        send_text("\\u12", 1'b1, 1'b1);
        wait_drained();

        // output held off while input streams without gaps
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold = HOLD_CYCLES;
        burst_end = rand_items + 30;
        while (rand_items < burst_end)
            play_random_value();
        wait_drained();

        while (rand_items < RANDOM_ITEMS)
        begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            play_random_value();
            if (!paused && rand_items >= RANDOM_ITEMS / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end
        wait_drained();

        $display("run covered %0d input words and %0d results over %0d finished values",
                 words_in, results_out, values_ended);
        $display("%0d values closed by a quote, the rest cut off by end of body",
                 values_closed);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
rtl/jsu_pkg.sv
rtl/json_string_unescape_utf8_unit.sv
test/unescape_checker.sv
test/testbench.sv
